// ----- rtl/csfw_pkg.sv -----
// ----------------------------------------------------------------------------
// csfw_pkg: shared definitions for the counting semaphore
// Operation and status codes, default sizes and the control/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package csfw_pkg;

  localparam int WAIT_DEPTH_DEF     = 16;
  localparam int THREAD_ID_BITS_DEF = 8;
  localparam int COUNT_BITS_DEF     = 16;

  localparam int UNITS_BITS   = 16;
  localparam int INIT_BITS    = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    KIND_WAIT   = 2'd0,
    KIND_SIGNAL = 2'd1,
    KIND_CLOSE  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ACQUIRED    = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_NOOP        = 3'd2,
    ST_SIGNALLED   = 3'd3,
    ST_CLOSED_ERR  = 3'd4,
    ST_CLOSED_DONE = 3'd5,
    ST_FULL        = 3'd6
  } status_t;

  typedef struct packed {
    logic    load_item;
    logic    acquire;
    logic    push;
    logic    add;
    logic    pop;
    logic    sub_head;
    logic    close_set;
    logic    clear_ptrs;
    logic    res_clear;
    logic    res_inc;
    logic    pend_load;
    status_t pend_status;
    logic    out_pend;
    logic    out_pend_last;
    logic    out_direct;
    status_t direct_status;
  } csfw_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  closed;
    logic  units_zero;
    logic  count_ge_units;
    logic  full;
    logic  fill_zero;
    logic  count_ge_head;
    logic  res_zero;
    logic  res_lt_max;
    logic  out_free;
  } csfw_stat_t;

endpackage

`default_nettype wire

// ----- rtl/csfw_dp.sv -----
// ----------------------------------------------------------------------------
// csfw_dp: semaphore datapath
// Count, closed flag, waiter queue memory and pointers, the staged result
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csfw_dp
  import csfw_pkg::*;
#(
  parameter int WAIT_DEPTH     = WAIT_DEPTH_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  csfw_cmd_t                 cmd,
  output csfw_stat_t                stat,
  input  logic                      cfg_write_en,
  input  logic [INIT_BITS-1:0]      cfg_write_data,
  input  logic [1:0]                kind,
  input  logic [THREAD_ID_BITS-1:0] thread_id,
  input  logic [UNITS_BITS-1:0]     units,
  output logic                      out_valid,
  input  logic                      out_ready,
  output status_t                   out_status,
  output logic                      woken_valid,
  output logic [THREAD_ID_BITS-1:0] woken_thread,
  output logic [COUNT_BITS-1:0]     count_now,
  output logic                      last
);

  localparam int PTR_BITS  = $clog2(WAIT_DEPTH);
  localparam int FILL_BITS = $clog2(WAIT_DEPTH + 1);
  localparam int CW        = (COUNT_BITS > UNITS_BITS) ? COUNT_BITS : UNITS_BITS;

  localparam logic [CW:0] COUNT_MAX_W = {{(CW + 1 - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

  logic [THREAD_ID_BITS-1:0] mem_thread [WAIT_DEPTH];
  logic [UNITS_BITS-1:0]     mem_req    [WAIT_DEPTH];
  logic [THREAD_ID_BITS-1:0] rd_thread;
  logic [UNITS_BITS-1:0]     rd_req;

  kind_t                     kind_r;
  logic [THREAD_ID_BITS-1:0] tid_r;
  logic [UNITS_BITS-1:0]     units_r;

  logic [COUNT_BITS-1:0]   count, count_next;
  logic                    closed;
  logic [PTR_BITS-1:0]     head, tail;
  logic [FILL_BITS-1:0]    fill;
  logic [RES_CNT_BITS-1:0] res_cnt;

  status_t                   pend_status;
  logic [THREAD_ID_BITS-1:0] pend_tid;
  logic [COUNT_BITS-1:0]     pend_count;

  logic [CW-1:0] count_w, units_w, req_w;
  logic [CW:0]   sum_w;
  logic [CW-1:0] diff_units, diff_req;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    ptr_inc = (p == PTR_BITS'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign count_w    = CW'(count);
  assign units_w    = CW'(units_r);
  assign req_w      = CW'(rd_req);
  assign sum_w      = {1'b0, count_w} + {1'b0, units_w};
  assign diff_units = count_w - units_w;
  assign diff_req   = count_w - req_w;

  always_comb begin
    count_next = count;
    if (cfg_write_en) begin
      count_next = COUNT_BITS'(cfg_write_data);
    end else if (cmd.acquire) begin
      count_next = diff_units[COUNT_BITS-1:0];
    end else if (cmd.add) begin
      count_next = (sum_w > COUNT_MAX_W) ? COUNT_MAX_W[COUNT_BITS-1:0] : sum_w[COUNT_BITS-1:0];
    end else if (cmd.pop && cmd.sub_head) begin
      count_next = diff_req[COUNT_BITS-1:0];
    end
  end

  assign stat.kind           = kind_r;
  assign stat.closed         = closed;
  assign stat.units_zero     = (units_r == '0);
  assign stat.count_ge_units = (count_w >= units_w);
  assign stat.full           = (fill == FILL_BITS'(WAIT_DEPTH));
  assign stat.fill_zero      = (fill == '0);
  assign stat.count_ge_head  = (count_w >= req_w);
  assign stat.res_zero       = (res_cnt == '0);
  assign stat.res_lt_max     = (res_cnt < RES_CNT_BITS'(MAX_RESULTS));
  assign stat.out_free       = !out_valid || out_ready;

  // queue storage, registered read of the head slot
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem_thread[tail] <= tid_r;
      mem_req[tail]    <= units_r;
    end
    rd_thread <= mem_thread[head];
    rd_req    <= mem_req[head];
  end

  // item, staged result and output payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r  <= kind_t'(kind);
      tid_r   <= thread_id;
      units_r <= units;
    end
    if (cmd.pend_load) begin
      pend_status <= cmd.pend_status;
      pend_tid    <= rd_thread;
      pend_count  <= count_next;
    end
    if (cmd.out_direct) begin
      out_status   <= cmd.direct_status;
      woken_valid  <= 1'b0;
      woken_thread <= '0;
      count_now    <= count_next;
      last         <= 1'b1;
    end else if (cmd.out_pend) begin
      out_status   <= pend_status;
      woken_valid  <= 1'b1;
      woken_thread <= pend_tid;
      count_now    <= pend_count;
      last         <= cmd.out_pend_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      closed    <= 1'b0;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      res_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.close_set) begin
        closed <= 1'b1;
      end
      if (cmd.clear_ptrs) begin
        head <= '0;
        tail <= '0;
      end else begin
        if (cmd.pop) begin
          head <= ptr_inc(head);
        end
        if (cmd.push) begin
          tail <= ptr_inc(tail);
        end
      end
      if (cmd.push) begin
        fill <= fill + 1'b1;
      end else if (cmd.pop) begin
        fill <= fill - 1'b1;
      end
      if (cmd.res_clear) begin
        res_cnt <= '0;
      end else if (cmd.res_inc) begin
        res_cnt <= res_cnt + 1'b1;
      end
      if (cmd.out_direct || cmd.out_pend) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/csfw_ctrl.sv -----
// ----------------------------------------------------------------------------
// csfw_ctrl: semaphore controller
// Decodes the held word and sequences the queue walk for signal and close.
// ----------------------------------------------------------------------------
`default_nettype none

module csfw_ctrl
  import csfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  csfw_stat_t stat,
  output csfw_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_TEST
  } state_t;

  state_t state, state_next;
  logic   is_close;
  logic   more;

  assign in_ready = (state == S_IDLE) && !rst;
  assign is_close = (stat.kind == KIND_CLOSE);
  // another waiter leaves the queue
  assign more = is_close ? !stat.fill_zero
                         : (!stat.fill_zero && stat.res_lt_max && stat.count_ge_head);

  always_comb begin
    cmd         = '0;
    cmd.pend_status   = is_close ? ST_CLOSED_DONE : ST_SIGNALLED;
    cmd.direct_status = ST_NOOP;
    cmd.sub_head      = !is_close;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (stat.kind == KIND_UNUSED) begin
          cmd.direct_status = ST_NOOP;
          cmd.out_direct    = stat.out_free;
        end else if (stat.closed) begin
          cmd.direct_status = ST_CLOSED_ERR;
          cmd.out_direct    = stat.out_free;
        end else if (is_close) begin
          cmd.close_set = 1'b1;
          cmd.res_clear = 1'b1;
        end else if (stat.units_zero) begin
          cmd.direct_status = ST_NOOP;
          cmd.out_direct    = stat.out_free;
        end else if (stat.kind == KIND_SIGNAL) begin
          cmd.add       = 1'b1;
          cmd.res_clear = 1'b1;
        end else if (stat.count_ge_units) begin
          cmd.direct_status = ST_ACQUIRED;
          cmd.out_direct    = stat.out_free;
          cmd.acquire       = stat.out_free;
        end else if (stat.full) begin
          cmd.direct_status = ST_FULL;
          cmd.out_direct    = stat.out_free;
        end else begin
          cmd.direct_status = ST_QUEUED;
          cmd.out_direct    = stat.out_free;
          cmd.push          = stat.out_free;
        end
        if (cmd.out_direct) begin
          state_next = S_IDLE;
        end else if (cmd.add || cmd.close_set) begin
          state_next = S_TEST;
        end
      end
      S_READ: begin
        state_next = S_TEST;
      end
      S_TEST: begin
        priority if (stat.res_zero) begin
          if (more) begin
            cmd.pop       = 1'b1;
            cmd.pend_load = 1'b1;
            cmd.res_inc   = 1'b1;
            state_next    = S_READ;
          end else if (stat.out_free) begin
            cmd.direct_status = is_close ? ST_CLOSED_DONE : ST_SIGNALLED;
            cmd.out_direct    = 1'b1;
            cmd.clear_ptrs    = is_close;
            state_next        = S_IDLE;
          end
        end else if (more && !stat.res_lt_max) begin
          // result limit reached: close drains the rest unreported
          cmd.pop = 1'b1;
        end else if (stat.out_free) begin
          cmd.out_pend      = 1'b1;
          cmd.out_pend_last = !more;
          if (more) begin
            cmd.pop       = 1'b1;
            cmd.pend_load = 1'b1;
            cmd.res_inc   = 1'b1;
            state_next    = S_READ;
          end else begin
            cmd.clear_ptrs = is_close;
            state_next     = S_IDLE;
          end
        end else begin
          // output register still occupied: hold the staged result
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/counting_semaphore_fifo_waiters.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters: counting semaphore with FIFO wait queue
// Wait, signal and close operations on one count; blocked waiters are held
// in a queue memory and woken in strict order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per operation: kind,
//   thread_id, units. Output channel (out_valid/out_ready) returns one or
//   more result words per operation; last marks the final one.
//   cfg_write_en/cfg_write_data load the count; write only while idle.
// Sequencing:
//   One operation is taken at a time. A wait, a zero-unit or unused-kind word,
//   or any word once closed is accepted, then executed. A signal or close is
//   accepted, executed and tested, then each woken thread passes a read state
//   and a test state: the head entry comes out of the queue memory through a
//   registered read port, so each wake costs a read and a test.
//   A close past 16 reported wakes drains the rest at one waiter per cycle.
// Reset:
//   rst (synchronous) clears count to 0, the closed flag, queue pointers and
//   fill, and holds in_ready low; queue memory is not cleared, needs no sweep.
// Stall:
//   A result waits in the output register while out_ready is low; the next
//   operation is still accepted, and the engine holds only when it has
//   another result to place.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_fifo_waiters
  import csfw_pkg::*;
#(
  parameter int WAIT_DEPTH     = WAIT_DEPTH_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [INIT_BITS-1:0]      cfg_write_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                kind,
  input  logic [THREAD_ID_BITS-1:0] thread_id,
  input  logic [UNITS_BITS-1:0]     units,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic                      woken_valid,
  output logic [THREAD_ID_BITS-1:0] woken_thread,
  output logic [COUNT_BITS-1:0]     count_now,
  output logic                      last
);

  csfw_cmd_t  cmd;   // controller -> datapath
  csfw_stat_t stat;  // datapath -> controller
  status_t    out_status;

  assign status = out_status;

  csfw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csfw_dp #(
    .WAIT_DEPTH     (WAIT_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .kind           (kind),
    .thread_id      (thread_id),
    .units          (units),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .woken_valid    (woken_valid),
    .woken_thread   (woken_thread),
    .count_now      (count_now),
    .last           (last)
  );

  // one operation in flight: no second accept right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while previous operation still executing");

  // never push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && stat.full))
    else $error("push into full wait queue");

  // a result is never placed over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_direct || cmd.out_pend) |-> (!out_valid || out_ready))
    else $error("output register overwritten while stalled");

  // results that wake no thread carry no thread id and are the last word
  a_woken_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !woken_valid) |-> (woken_thread == '0 && last))
    else $error("non-wake result with thread id or without last");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: counting semaphore with FIFO wait queue
// Drives wait, signal and close words through the input channel and checks
// every result word against a software copy of the semaphore: count, closed
// flag and a 16-entry waiter ring. Covers saturation, head-of-line blocking,
// full queue, batch wakes and the closed state, with random idling on both
// channels and a long output stall.
// ----------------------------------------------------------------------------

import csfw_pkg::*;

typedef struct packed {
  status_t     status;
  logic        woken_valid;
  logic [7:0]  woken_thread;
  logic [15:0] count_now;
  logic        last_word;
} sem_result_t;

// Expected-result store plus the semaphore predictor that fills it.
class sem_scoreboard;
  logic [15:0] count;
  bit          closed;
  logic [7:0]  wq_thread [WAIT_DEPTH_DEF];
  logic [15:0] wq_request[WAIT_DEPTH_DEF];
  int unsigned head;
  int unsigned tail;
  int unsigned fill;
  sem_result_t expected_q[$];
  sem_result_t burst[MAX_RESULTS];
  int          burst_len;
  int          fails;

  function new();
    count  = '0;
    closed = 0;
    head   = 0;
    tail   = 0;
    fill   = 0;
    fails  = 0;
  endfunction

  function void load_initial(logic [15:0] v);
    count = v;
  endfunction

  function int waiting();
    return expected_q.size();
  endfunction

  function void put(status_t s, bit wv, logic [7:0] wt);
    sem_result_t r;
    r.status       = s;
    r.woken_valid  = wv;
    r.woken_thread = wv ? wt : 8'd0;
    r.count_now    = count;
    r.last_word    = 1'b0;
    burst[burst_len] = r;
    burst_len++;
  endfunction

  function logic [7:0] pop_waiter();
    logic [7:0] t;
    t    = wq_thread[head];
    head = (head + 1) % WAIT_DEPTH_DEF;
    fill--;
    return t;
  endfunction

  // Apply one accepted operation and queue the words it must produce.
  function void note_word(kind_t k, logic [7:0] tid, logic [15:0] u);
    logic [16:0] sum;
    logic [7:0]  t;
    burst_len = 0;
    if (k == KIND_UNUSED) begin
      put(ST_NOOP, 0, 8'd0);
    end else if (closed) begin
      put(ST_CLOSED_ERR, 0, 8'd0);
    end else if (k == KIND_CLOSE) begin
      closed = 1;
      while (fill > 0) begin
        t = pop_waiter();
        if (burst_len < MAX_RESULTS) put(ST_CLOSED_DONE, 1, t);
      end
      head = 0;
      tail = 0;
      if (burst_len == 0) put(ST_CLOSED_DONE, 0, 8'd0);
    end else if (u == 16'd0) begin
      put(ST_NOOP, 0, 8'd0);
    end else if (k == KIND_WAIT) begin
      if (count >= u) begin
        count = count - u;
        put(ST_ACQUIRED, 0, 8'd0);
      end else if (fill >= WAIT_DEPTH_DEF) begin
        put(ST_FULL, 0, 8'd0);
      end else begin
        wq_thread[tail]  = tid;
        wq_request[tail] = u;
        tail = (tail + 1) % WAIT_DEPTH_DEF;
        fill++;
        put(ST_QUEUED, 0, 8'd0);
      end
    end else begin
      sum   = {1'b0, count} + {1'b0, u};
      count = sum[16] ? 16'hFFFF : sum[15:0];
      // strict FIFO: stop at the first head the count cannot cover
      while (fill > 0 && burst_len < MAX_RESULTS && count >= wq_request[head]) begin
        count = count - wq_request[head];
        t = pop_waiter();
        put(ST_SIGNALLED, 1, t);
      end
      if (burst_len == 0) put(ST_SIGNALLED, 0, 8'd0);
    end
    burst[burst_len-1].last_word = 1'b1;
    for (int i = 0; i < burst_len; i++) expected_q.push_back(burst[i]);
  endfunction

  task report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fails++;
  endtask

  task check_word(sem_result_t got);
    sem_result_t want;
    string       got_s;
    string       want_s;
    got_s = $sformatf("st=%0d wv=%0b wt=%0d cnt=%0d last=%0b",
                      got.status, got.woken_valid, got.woken_thread,
                      got.count_now, got.last_word);
    if (expected_q.size() == 0) begin
      report({"unexpected word ", got_s});
      return;
    end
    want = expected_q.pop_front();
    want_s = $sformatf("st=%0d wv=%0b wt=%0d cnt=%0d last=%0b",
                       want.status, want.woken_valid, want.woken_thread,
                       want.count_now, want.last_word);
    if (got !== want)
      report({"got ", got_s, ", want ", want_s});
  endtask
endclass

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;   // long output stall to back up the input
  localparam int PHASE_OPS   = 72;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [15:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [7:0]  thread_id = '0;
  logic [15:0] units = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic        woken_valid;
  logic [7:0]  woken_thread;
  logic [15:0] count_now;
  logic        last;

  sem_scoreboard board = new();

  int snd_pct = 38;       // percent chance the sender idles in a cycle
  int rcv_pct = 61;       // percent chance the receiver stalls in a cycle
  int hold_asks = 0;      // bumped by the driver to request a long stall
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  always #2 clk = ~clk;

  counting_semaphore_fifo_waiters u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .thread_id      (thread_id),
    .units          (units),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .woken_valid    (woken_valid),
    .woken_thread   (woken_thread),
    .count_now      (count_now),
    .last           (last)
  );

  // Receiver: random stall, or a long hold-off counted down here when asked.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_pct);
    end
  end

  // Output monitor: values sampled here are the ones held before the edge.
  always @(posedge clk) begin
    sem_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.status       = status_t'(status);
      got.woken_valid  = woken_valid;
      got.woken_thread = woken_thread;
      got.count_now    = count_now;
      got.last_word    = last;
      board.check_word(got);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Offer one word; valid stays up with the payload fixed until accepted.
  task automatic send_word(kind_t k, logic [7:0] t, logic [15:0] u);
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    thread_id <= t;
    units     <= u;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(k, t, u);
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
  endtask

  // Count register is only loaded while the block is idle.
  task automatic load_count(logic [15:0] v);
    drain();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    board.load_initial(v);
    cfg_write_en <= 1'b0;
  endtask

  // Mostly small requests so waits queue and signals release them;
  // full-range and maximum values hit saturation and every units bit.
  function automatic logic [15:0] pick_units();
    int r;
    r = $urandom_range(99);
    if (r < 4)  return 16'd0;
    if (r < 50) return 16'($urandom_range(16, 1));
    if (r < 80) return 16'($urandom_range(2000, 1));
    if (r < 95) return 16'($urandom_range(65535, 0));
    return 16'hFFFF;
  endfunction

  // One random phase; kind 3 noise is not counted toward the total.
  task automatic run_random(int n_ops, bit do_hold, bit do_pause);
    int done_ops;
    int r;
    done_ops = 0;
    while (done_ops < n_ops) begin
      r = $urandom_range(99);
      if (r < 48) begin
        send_word(KIND_WAIT, 8'($urandom_range(255, 0)), pick_units());
        done_ops++;
      end else if (r < 94) begin
        send_word(KIND_SIGNAL, 8'($urandom_range(255, 0)), pick_units());
        done_ops++;
      end else begin
        send_word(KIND_UNUSED, 8'($urandom_range(255, 0)),
                  16'($urandom_range(65535, 0)));
      end
      // sender keeps pushing through the hold so the input backs up
      if (do_hold && done_ops == n_ops / 3 && r < 94) hold_asks++;
      if (do_pause && done_ops == n_ops / 2 && r < 94) drain();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed: count starts at 0 out of reset ----
    send_word(KIND_UNUSED, 8'hFF, 16'hFFFF);   // unused kind is a no-op
    send_word(KIND_WAIT,   8'h0F, 16'd0);      // zero-unit wait
    send_word(KIND_SIGNAL, 8'hF0, 16'd0);      // zero-unit signal
    send_word(KIND_SIGNAL, 8'h00, 16'd5);      // signal, nobody to wake
    send_word(KIND_WAIT,   8'hFF, 16'd100);    // queued
    send_word(KIND_WAIT,   8'h00, 16'd10);     // queued behind the big one
    send_word(KIND_SIGNAL, 8'h11, 16'd50);     // head blocks the small waiter
    send_word(KIND_SIGNAL, 8'h22, 16'hFFFF);   // saturates, wakes both
    send_word(KIND_WAIT,   8'h5A, 16'd65425);  // takes the rest
    load_count(16'd0);
    for (int i = 0; i < WAIT_DEPTH_DEF; i++)
      send_word(KIND_WAIT, {4'(i), ~4'(i)}, 16'(i + 1));
    send_word(KIND_WAIT,   8'hA5, 16'd7);      // queue full
    send_word(KIND_SIGNAL, 8'h5A, 16'hFFFF);   // wakes all sixteen

    // ---- random phases: idle mix changes, count reloaded between them ----
    load_count(16'($urandom_range(65534, 1)));
    snd_pct = 38;
    rcv_pct = 61;
    run_random(PHASE_OPS, 1'b1, 1'b0);

    load_count(16'hFFFF);
    snd_pct = 61;
    rcv_pct = 38;
    run_random(PHASE_OPS, 1'b0, 1'b1);

    load_count(16'd0);
    snd_pct = 0;
    rcv_pct = 0;
    run_random(PHASE_OPS, 1'b0, 1'b0);

    // ---- close tail: closing is sticky, so it comes last ----
    load_count(16'd0);
    snd_pct = 20;
    rcv_pct = 30;
    for (int i = 0; i < WAIT_DEPTH_DEF; i++)
      send_word(KIND_WAIT, 8'($urandom_range(255, 0)), 16'd1000);
    send_word(KIND_CLOSE,  8'h00, 16'd0);      // wakes every waiter
    send_word(KIND_WAIT,   8'h12, 16'd5);      // closed error
    send_word(KIND_SIGNAL, 8'h34, 16'd5);
    send_word(KIND_CLOSE,  8'h56, 16'd0);
    send_word(KIND_UNUSED, 8'h78, 16'd1);      // still a plain no-op

    drain();
    repeat (40) @(posedge clk);   // catch any stray extra words
    if (board.fails == 0 && board.waiting() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
